>>> hw/rtl/tasl_pkg.sv
package tasl_pkg;

   // field widths
   localparam int DELTA_W = 13;
   localparam int COUNT_W = 12;
   localparam int SPEED_W = 16;
   localparam int DELAY_W = 29;
   localparam int PHASE_W = 3;
   localparam int COIL_W  = 4;

   // iterative square root and divider sizes
   localparam int RAD_W  = 2 * COUNT_W + 2;
   localparam int ROOT_W = RAD_W / 2;
   localparam int PROD_W = SPEED_W + ROOT_W;
   localparam int UNIT_W = 16;
   localparam int CNT_W  = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 16'd65535;

   localparam logic [CNT_W-1:0] ROOT_STEPS_LAST = CNT_W'(ROOT_W - 1);
   localparam logic [CNT_W-1:0] DIV_STEPS_LAST  = CNT_W'(DELAY_W - 1);

   localparam logic [PHASE_W-1:0] PHASE_FWD = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_REV = 3'd7;

   // half-step coil ring, bit0 coil1 .. bit3 coil4
   localparam logic [COIL_W-1:0] RING_COILS [8] = '{
      4'd1, 4'd5, 4'd4, 4'd6, 4'd2, 4'd10, 4'd8, 4'd9
   };

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_CALC,
      TOP_REPLY
   } top_state_type;

   typedef enum logic [2:0] {
      CALC_IDLE,
      CALC_SQRX,
      CALC_SQRY,
      CALC_ROOT,
      CALC_MUL,
      CALC_DIVX,
      CALC_DIVY,
      CALC_DONE
   } calc_state_type;

   typedef struct packed {
      logic               start;
      logic [SPEED_W-1:0] speed;
   } calc_ctl_type;

   typedef struct packed {
      logic               done;
      logic [DELAY_W-1:0] x_interval;
      logic [DELAY_W-1:0] y_interval;
   } calc_sts_type;

   // magnitude of a signed count, saturated to COUNT_MAX
   function automatic logic [COUNT_W-1:0] count_mag(input logic [DELTA_W-1:0] v);
      logic [DELTA_W:0] mag;
      mag = v[DELTA_W-1] ? ((DELTA_W+1)'(1) << DELTA_W) - {1'b0, v} : {1'b0, v};
      return (mag > {{(DELTA_W+1-COUNT_W){1'b0}}, COUNT_MAX}) ? COUNT_MAX
                                                            : mag[COUNT_W-1:0];
   endfunction

   function automatic logic count_fwd(input logic [DELTA_W-1:0] v);
      return !v[DELTA_W-1] && (v != '0);
   endfunction

endpackage

>>> hw/rtl/tasl_calc.sv
module tasl_calc (
   input  logic                          clock,
   input  logic                          reset,
   input  tasl_pkg::calc_ctl_type        ctl,
   input  logic [tasl_pkg::COUNT_W-1:0]  x_count,
   input  logic [tasl_pkg::COUNT_W-1:0]  y_count,
   output tasl_pkg::calc_sts_type        sts
);

   tasl_pkg::calc_state_type state_ff, state_in;

   logic [tasl_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [tasl_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic [tasl_pkg::RAD_W-1:0]   rad_ff, rad_in;
   logic [tasl_pkg::UNIT_W-1:0]  rem_ff, rem_in;
   logic [tasl_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [tasl_pkg::DELAY_W-1:0] total_ff, total_in;
   logic [tasl_pkg::DELAY_W-1:0] div_ff, div_in;
   logic [tasl_pkg::DELAY_W-1:0] x_int_ff, x_int_in;
   logic [tasl_pkg::DELAY_W-1:0] y_int_ff, y_int_in;

   // shared multiplier
   logic [tasl_pkg::SPEED_W-1:0] mul_a;
   logic [tasl_pkg::ROOT_W-1:0]  mul_b;
   logic [tasl_pkg::PROD_W-1:0]  prod;

   // shared subtract and compare unit
   logic [tasl_pkg::UNIT_W-1:0] sub_a, sub_b;
   logic [tasl_pkg::UNIT_W:0]   sub_diff;
   logic                        sub_ge;

   logic [tasl_pkg::COUNT_W-1:0] divisor;
   logic                         last_step;

   assign last_step = (cnt_ff == '0);
   assign divisor   = (state_ff == tasl_pkg::CALC_DIVY) ? y_count : x_count;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         tasl_pkg::CALC_SQRX: begin
            mul_a = tasl_pkg::SPEED_W'(x_count);
            mul_b = tasl_pkg::ROOT_W'(x_count);
         end
         tasl_pkg::CALC_SQRY: begin
            mul_a = tasl_pkg::SPEED_W'(y_count);
            mul_b = tasl_pkg::ROOT_W'(y_count);
         end
         tasl_pkg::CALC_MUL: begin
            mul_a = speed_ff;
            mul_b = root_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = tasl_pkg::PROD_W'(mul_a) * tasl_pkg::PROD_W'(mul_b);

   always_comb begin
      if (state_ff == tasl_pkg::CALC_ROOT) begin
         // remainder gets the next two radicand bits, trial is 4*root + 1
         sub_a = {rem_ff[tasl_pkg::UNIT_W-3:0], rad_ff[tasl_pkg::RAD_W-1 -: 2]};
         sub_b = tasl_pkg::UNIT_W'({root_ff[tasl_pkg::ROOT_W-2:0], 2'b01});
      end else begin
         sub_a = tasl_pkg::UNIT_W'({rem_ff[tasl_pkg::COUNT_W-1:0],
                                    div_ff[tasl_pkg::DELAY_W-1]});
         sub_b = tasl_pkg::UNIT_W'(divisor);
      end
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[tasl_pkg::UNIT_W];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tasl_pkg::CALC_IDLE: if (ctl.start) state_in = tasl_pkg::CALC_SQRX;
         tasl_pkg::CALC_SQRX: state_in = tasl_pkg::CALC_SQRY;
         tasl_pkg::CALC_SQRY: state_in = tasl_pkg::CALC_ROOT;
         tasl_pkg::CALC_ROOT: if (last_step) state_in = tasl_pkg::CALC_MUL;
         tasl_pkg::CALC_MUL: begin
            if (x_count != '0)      state_in = tasl_pkg::CALC_DIVX;
            else if (y_count != '0) state_in = tasl_pkg::CALC_DIVY;
            else                    state_in = tasl_pkg::CALC_DONE;
         end
         tasl_pkg::CALC_DIVX: begin
            if (last_step) begin
               state_in = (y_count != '0) ? tasl_pkg::CALC_DIVY : tasl_pkg::CALC_DONE;
            end
         end
         tasl_pkg::CALC_DIVY: if (last_step) state_in = tasl_pkg::CALC_DONE;
         tasl_pkg::CALC_DONE: state_in = tasl_pkg::CALC_IDLE;
         default:             state_in = tasl_pkg::CALC_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in   = cnt_ff;
      speed_in = speed_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      total_in = total_ff;
      div_in   = div_ff;
      x_int_in = x_int_ff;
      y_int_in = y_int_ff;
      case (state_ff)
         tasl_pkg::CALC_IDLE: begin
            if (ctl.start) begin
               speed_in = (ctl.speed > tasl_pkg::SPEED_MAX) ? tasl_pkg::SPEED_MAX
                                                            : ctl.speed;
            end
         end
         tasl_pkg::CALC_SQRX: rad_in = prod[tasl_pkg::RAD_W-1:0];
         tasl_pkg::CALC_SQRY: begin
            rad_in  = rad_ff + prod[tasl_pkg::RAD_W-1:0];
            rem_in  = '0;
            root_in = '0;
            cnt_in  = tasl_pkg::ROOT_STEPS_LAST;
         end
         tasl_pkg::CALC_ROOT: begin
            rad_in  = rad_ff << 2;
            rem_in  = sub_ge ? sub_diff[tasl_pkg::UNIT_W-1:0] : sub_a;
            root_in = {root_ff[tasl_pkg::ROOT_W-2:0], sub_ge};
            cnt_in  = cnt_ff - 1'b1;
         end
         tasl_pkg::CALC_MUL: begin
            // product fits the delay width, so no saturation happens here
            total_in = prod[tasl_pkg::DELAY_W-1:0];
            div_in   = prod[tasl_pkg::DELAY_W-1:0];
            rem_in   = '0;
            cnt_in   = tasl_pkg::DIV_STEPS_LAST;
            x_int_in = '0;
            y_int_in = '0;
         end
         tasl_pkg::CALC_DIVX, tasl_pkg::CALC_DIVY: begin
            rem_in = sub_ge ? sub_diff[tasl_pkg::UNIT_W-1:0] : sub_a;
            div_in = {div_ff[tasl_pkg::DELAY_W-2:0], sub_ge};
            cnt_in = cnt_ff - 1'b1;
            if (last_step) begin
               if (state_ff == tasl_pkg::CALC_DIVX) begin
                  x_int_in = {div_ff[tasl_pkg::DELAY_W-2:0], sub_ge};
                  div_in   = total_ff;
                  rem_in   = '0;
                  cnt_in   = tasl_pkg::DIV_STEPS_LAST;
               end else begin
                  y_int_in = {div_ff[tasl_pkg::DELAY_W-2:0], sub_ge};
               end
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tasl_pkg::CALC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      speed_ff <= speed_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      total_ff <= total_in;
      div_ff   <= div_in;
      x_int_ff <= x_int_in;
      y_int_ff <= y_int_in;
   end

   assign sts.done       = (state_ff == tasl_pkg::CALC_DONE);
   assign sts.x_interval = x_int_ff;
   assign sts.y_interval = y_int_ff;

endmodule

>>> hw/rtl/two_axis_stepper_line_mover.sv
// Straight-line mover for two half-stepped motors. A start item (mode 0) latches signed step
// counts and a speed, then forms total = speed * floor(sqrt(dx*dx + dy*dy)) and the per-axis
// intervals total/|dx| and total/|dy|; each advance item (mode 1) returns one step event with
// the coil patterns, directions and the delay in microseconds to wait afterwards. From its
// acceptance to its result a start runs through squaring the counts on the shared multiplier,
// 13 square root steps, one multiply, 29 restoring division steps per nonzero axis on one
// shared subtractor, a done state that hands the intervals over and the load of the result
// register; an axis with a zero count skips its division. Advance items and rejected items
// (start while moving, advance while idle) are answered straight into the result register
// and can be taken every cycle while no start is in progress and the result register drains.
module two_axis_stepper_line_mover (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic signed [tasl_pkg::DELTA_W-1:0] req_delta_x,
   input  logic signed [tasl_pkg::DELTA_W-1:0] req_delta_y,
   input  logic [tasl_pkg::SPEED_W-1:0]        req_speed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic                                rsp_x_stepped,
   output logic                                rsp_y_stepped,
   output logic                                rsp_x_forward,
   output logic                                rsp_y_forward,
   output logic [tasl_pkg::COIL_W-1:0]         rsp_x_coils,
   output logic [tasl_pkg::COIL_W-1:0]         rsp_y_coils,
   output logic [tasl_pkg::DELAY_W-1:0]        rsp_delay_us,
   output logic                                rsp_move_done
);

   tasl_pkg::top_state_type state_ff, state_in;

   // move state
   logic [tasl_pkg::PHASE_W-1:0] x_phase_ff, x_phase_in, y_phase_ff, y_phase_in;
   logic [tasl_pkg::COUNT_W-1:0] x_rem_ff, x_rem_in, y_rem_ff, y_rem_in;
   logic [tasl_pkg::DELAY_W-1:0] x_int_ff, x_int_in, y_int_ff, y_int_in;
   logic [tasl_pkg::DELAY_W-1:0] x_wait_ff, x_wait_in, y_wait_ff, y_wait_in;
   logic [tasl_pkg::COIL_W-1:0]  x_held_ff, x_held_in, y_held_ff, y_held_in;
   logic                         x_fwd_ff, x_fwd_in, y_fwd_ff, y_fwd_in;
   logic                         moving_ff, moving_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         acc_ff, acc_in, xs_ff, xs_in, ys_ff, ys_in;
   logic                         xf_ff, xf_in, yf_ff, yf_in, done_ff, done_in;
   logic [tasl_pkg::COIL_W-1:0]  xc_ff, xc_in, yc_ff, yc_in;
   logic [tasl_pkg::DELAY_W-1:0] dly_ff, dly_in;

   // handshake and control
   logic req_fire, rsp_free, start_go, advance_go, reply_load;

   tasl_pkg::calc_ctl_type calc_ctl;
   tasl_pkg::calc_sts_type calc_sts;

   // step decision
   logic                         both_left, x_lt, x_eq, xs, ys;
   logic [tasl_pkg::DELAY_W:0]   wait_diff;
   logic [tasl_pkg::DELAY_W-1:0] delay;
   logic [tasl_pkg::COUNT_W-1:0] x_rem_next, y_rem_next;
   logic [tasl_pkg::COIL_W-1:0]  x_pat, y_pat;
   logic [tasl_pkg::COUNT_W-1:0] start_ax, start_ay;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tasl_pkg::TOP_IDLE:  if (start_go) state_in = tasl_pkg::TOP_CALC;
         tasl_pkg::TOP_CALC:  if (calc_sts.done) state_in = tasl_pkg::TOP_REPLY;
         tasl_pkg::TOP_REPLY: if (rsp_free) state_in = tasl_pkg::TOP_IDLE;
         default:             state_in = tasl_pkg::TOP_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      reply_load = 1'b0;
      case (state_ff)
         tasl_pkg::TOP_IDLE:  req_ready  = rsp_free;
         tasl_pkg::TOP_REPLY: reply_load = rsp_free;
         default: begin
            req_ready  = 1'b0;
            reply_load = 1'b0;
         end
      endcase
   end

   // a start only acts while idle, an advance only while moving
   assign start_go   = req_fire && !req_mode && !moving_ff;
   assign advance_go = req_fire && req_mode && moving_ff;

   assign calc_ctl.start = start_go;
   assign calc_ctl.speed = req_speed;

   tasl_calc u_calc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (calc_ctl),
      .x_count (x_rem_ff),
      .y_count (y_rem_ff),
      .sts     (calc_sts)
   );

   assign start_ax = tasl_pkg::count_mag(req_delta_x);
   assign start_ay = tasl_pkg::count_mag(req_delta_y);

   // one subtract gives the order of the two waits and the leftover wait
   assign both_left = (x_rem_ff != '0) && (y_rem_ff != '0);
   assign wait_diff = {1'b0, x_wait_ff} - {1'b0, y_wait_ff};
   assign x_lt      = wait_diff[tasl_pkg::DELAY_W];
   assign x_eq      = (wait_diff == '0);

   always_comb begin
      if (both_left) begin
         xs    = x_lt || x_eq;
         ys    = !x_lt;
         delay = (x_lt || x_eq) ? x_wait_ff : y_wait_ff;
      end else begin
         // single axis left runs at its full interval
         xs    = (x_rem_ff != '0);
         ys    = (x_rem_ff == '0);
         delay = (x_rem_ff != '0) ? x_int_ff : y_int_ff;
      end
   end

   assign x_pat      = tasl_pkg::RING_COILS[x_phase_ff];
   assign y_pat      = tasl_pkg::RING_COILS[y_phase_ff];
   assign x_rem_next = xs ? x_rem_ff - 1'b1 : x_rem_ff;
   assign y_rem_next = ys ? y_rem_ff - 1'b1 : y_rem_ff;

   // move state update
   always_comb begin
      x_phase_in = x_phase_ff;
      y_phase_in = y_phase_ff;
      x_rem_in   = x_rem_ff;
      y_rem_in   = y_rem_ff;
      x_int_in   = x_int_ff;
      y_int_in   = y_int_ff;
      x_wait_in  = x_wait_ff;
      y_wait_in  = y_wait_ff;
      x_held_in  = x_held_ff;
      y_held_in  = y_held_ff;
      x_fwd_in   = x_fwd_ff;
      y_fwd_in   = y_fwd_ff;
      moving_in  = moving_ff;
      if (start_go) begin
         x_fwd_in  = tasl_pkg::count_fwd(req_delta_x);
         y_fwd_in  = tasl_pkg::count_fwd(req_delta_y);
         x_rem_in  = start_ax;
         y_rem_in  = start_ay;
         x_held_in = '0;
         y_held_in = '0;
         moving_in = (start_ax != '0) || (start_ay != '0);
      end
      if (calc_sts.done) begin
         x_int_in  = calc_sts.x_interval;
         y_int_in  = calc_sts.y_interval;
         x_wait_in = calc_sts.x_interval;
         y_wait_in = calc_sts.y_interval;
      end
      if (advance_go) begin
         if (both_left) begin
            if (x_eq) begin
               x_wait_in = x_int_ff;
               y_wait_in = y_int_ff;
            end else if (x_lt) begin
               x_wait_in = x_int_ff;
               y_wait_in = -wait_diff[tasl_pkg::DELAY_W-1:0];
            end else begin
               x_wait_in = wait_diff[tasl_pkg::DELAY_W-1:0];
               y_wait_in = y_int_ff;
            end
         end
         if (xs) begin
            x_phase_in = x_phase_ff + (x_fwd_ff ? tasl_pkg::PHASE_FWD : tasl_pkg::PHASE_REV);
         end
         if (ys) begin
            y_phase_in = y_phase_ff + (y_fwd_ff ? tasl_pkg::PHASE_FWD : tasl_pkg::PHASE_REV);
         end
         x_rem_in  = x_rem_next;
         y_rem_in  = y_rem_next;
         // coils release once the axis has no steps left
         x_held_in = (x_rem_next == '0) ? '0 : (xs ? x_pat : x_held_ff);
         y_held_in = (y_rem_next == '0) ? '0 : (ys ? y_pat : y_held_ff);
         moving_in = (x_rem_next != '0) || (y_rem_next != '0);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      acc_in       = acc_ff;
      xs_in        = xs_ff;
      ys_in        = ys_ff;
      xf_in        = xf_ff;
      yf_in        = yf_ff;
      xc_in        = xc_ff;
      yc_in        = yc_ff;
      dly_in       = dly_ff;
      done_in      = done_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (reply_load) begin
         // start result, coils idle and no delay
         rsp_valid_in = 1'b1;
         acc_in       = 1'b1;
         xs_in        = 1'b0;
         ys_in        = 1'b0;
         xf_in        = x_fwd_ff;
         yf_in        = y_fwd_ff;
         xc_in        = '0;
         yc_in        = '0;
         dly_in       = '0;
         done_in      = !moving_ff;
      end else if (req_fire && !start_go) begin
         rsp_valid_in = 1'b1;
         acc_in       = advance_go;
         xs_in        = advance_go && xs;
         ys_in        = advance_go && ys;
         xf_in        = advance_go && x_fwd_ff;
         yf_in        = advance_go && y_fwd_ff;
         xc_in        = advance_go ? (xs ? x_pat : x_held_ff) : '0;
         yc_in        = advance_go ? (ys ? y_pat : y_held_ff) : '0;
         dly_in       = advance_go ? delay : '0;
         done_in      = advance_go && (x_rem_next == '0) && (y_rem_next == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tasl_pkg::TOP_IDLE;
         x_phase_ff   <= '0;
         y_phase_ff   <= '0;
         x_rem_ff     <= '0;
         y_rem_ff     <= '0;
         x_held_ff    <= '0;
         y_held_ff    <= '0;
         x_fwd_ff     <= 1'b0;
         y_fwd_ff     <= 1'b0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_phase_ff   <= x_phase_in;
         y_phase_ff   <= y_phase_in;
         x_rem_ff     <= x_rem_in;
         y_rem_ff     <= y_rem_in;
         x_held_ff    <= x_held_in;
         y_held_ff    <= y_held_in;
         x_fwd_ff     <= x_fwd_in;
         y_fwd_ff     <= y_fwd_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_int_ff  <= x_int_in;
      y_int_ff  <= y_int_in;
      x_wait_ff <= x_wait_in;
      y_wait_ff <= y_wait_in;
      acc_ff    <= acc_in;
      xs_ff     <= xs_in;
      ys_ff     <= ys_in;
      xf_ff     <= xf_in;
      yf_ff     <= yf_in;
      xc_ff     <= xc_in;
      yc_ff     <= yc_in;
      dly_ff    <= dly_in;
      done_ff   <= done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = acc_ff;
   assign rsp_x_stepped = xs_ff;
   assign rsp_y_stepped = ys_ff;
   assign rsp_x_forward = xf_ff;
   assign rsp_y_forward = yf_ff;
   assign rsp_x_coils   = xc_ff;
   assign rsp_y_coils   = yc_ff;
   assign rsp_delay_us  = dly_ff;
   assign rsp_move_done = done_ff;

   // a stalled result blocks new items
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("item taken while result stalled");

   // the calculation only finishes while the top waits for it
   a_calc_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      calc_sts.done |-> (state_ff == tasl_pkg::TOP_CALC))
      else $error("calc done outside calc state");

   // idle means no steps left on either axis
   a_idle_no_steps: assert property (@(posedge clock) disable iff (reset)
      !moving_ff |-> ((x_rem_ff == '0) && (y_rem_ff == '0)))
      else $error("steps left while idle");

   // held coils only on an axis that still has steps
   a_held_needs_steps: assert property (@(posedge clock) disable iff (reset)
      ((x_held_ff == '0) || (x_rem_ff != '0)) && ((y_held_ff == '0) || (y_rem_ff != '0)))
      else $error("coils held on a finished axis");

   // on the last event of a move an axis that does not step is already released
   a_done_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_done) |->
         ((rsp_x_stepped || (rsp_x_coils == '0)) && (rsp_y_stepped || (rsp_y_coils == '0))))
      else $error("coils driven on move done");

endmodule

>>> test/tb_two_axis_stepper_line_mover.sv
module tb_two_axis_stepper_line_mover;

   // item modes on the request channel
   localparam bit MODE_START   = 1'b0;
   localparam bit MODE_ADVANCE = 1'b1;

   // full-scale signed counts, the most negative one saturates on the magnitude
   localparam logic signed [tasl_pkg::DELTA_W-1:0] DELTA_MIN = 13'sh1000;
   localparam logic signed [tasl_pkg::DELTA_W-1:0] DELTA_MAX = 13'sh0FFF;

   localparam longint DELAY_LIMIT = (longint'(1) << tasl_pkg::DELAY_W) - 1;
   localparam int     HOLD_CYCLES = 400;
   localparam int     PHASE_ITEMS = 200;
   localparam int     PHASE_COUNT = 6;
   localparam int     REPORT_CAP  = 30;

   // one step event as seen on the result channel
   typedef struct packed {
      logic                         accepted;
      logic                         x_stepped;
      logic                         y_stepped;
      logic                         x_forward;
      logic                         y_forward;
      logic [tasl_pkg::COIL_W-1:0]  x_coils;
      logic [tasl_pkg::COIL_W-1:0]  y_coils;
      logic [tasl_pkg::DELAY_W-1:0] delay_us;
      logic                         move_done;
   } step_event_type;

   // line-move predictor plus the queue of step events it has worked out
   class step_event_scoreboard;
      step_event_type expected_q[$];
      int             errors;
      bit             moving;
      bit [2:0]       x_phase, y_phase;
      int             x_left, y_left;
      longint         x_interval, y_interval, x_wait, y_wait;
      bit             x_fwd, y_fwd;
      logic [3:0]     x_held, y_held;

      function new();
         errors     = 0;
         moving     = 0;
         x_phase    = 0;
         y_phase    = 0;
         x_left     = 0;
         y_left     = 0;
         x_interval = 0;
         y_interval = 0;
         x_wait     = 0;
         y_wait     = 0;
         x_fwd      = 0;
         y_fwd      = 0;
         x_held     = 0;
         y_held     = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // coil1 on phases 7,0,1, coil2 on 3..5, coil3 on 1..3, coil4 on 5..7
      function logic [3:0] ring_pattern(bit [2:0] p);
         logic [3:0] pat;
         pat[0] = (p == 3'd7) || (p <= 3'd1);
         pat[1] = (p >= 3'd3) && (p <= 3'd5);
         pat[2] = (p >= 3'd1) && (p <= 3'd3);
         pat[3] = (p >= 3'd5);
         return pat;
      endfunction

      function int magnitude(logic signed [tasl_pkg::DELTA_W-1:0] d);
         int v;
         v = int'(d);
         if (v < 0) v = -v;
         if (v > int'(tasl_pkg::COUNT_MAX)) v = int'(tasl_pkg::COUNT_MAX);
         return v;
      endfunction

      function longint floor_root(longint v);
         longint r, t;
         r = 0;
         for (int b = 13; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      // works out the result of one accepted item, returns 1 if the item is acted on
      function bit note_item(bit mode, logic signed [tasl_pkg::DELTA_W-1:0] dx,
                             logic signed [tasl_pkg::DELTA_W-1:0] dy,
                             logic [tasl_pkg::SPEED_W-1:0] spd);
         step_event_type ev;
         int             ax, ay;
         longint         total, delay;
         bit             xs, ys;
         ev    = '0;
         xs    = 0;
         ys    = 0;
         delay = 0;
         if (mode == MODE_START) begin
            if (!moving) begin
               ax    = magnitude(dx);
               ay    = magnitude(dy);
               x_fwd = (dx > 0);
               y_fwd = (dy > 0);
               total = longint'(spd) * floor_root(longint'(ax) * ax + longint'(ay) * ay);
               if (total > DELAY_LIMIT) total = DELAY_LIMIT;
               x_interval = (ax != 0) ? total / ax : 0;
               y_interval = (ay != 0) ? total / ay : 0;
               x_wait     = x_interval;
               y_wait     = y_interval;
               x_left     = ax;
               y_left     = ay;
               x_held     = 0;
               y_held     = 0;
               moving     = (ax != 0) || (ay != 0);
               ev.accepted  = 1;
               ev.x_forward = x_fwd;
               ev.y_forward = y_fwd;
               ev.move_done = !moving;
            end
         end else if (moving) begin
            if (x_left != 0 && y_left != 0) begin
               if (x_wait < y_wait) begin
                  xs     = 1;
                  delay  = x_wait;
                  y_wait = y_wait - x_wait;
                  x_wait = x_interval;
               end else if (x_wait > y_wait) begin
                  ys     = 1;
                  delay  = y_wait;
                  x_wait = x_wait - y_wait;
                  y_wait = y_interval;
               end else begin
                  xs     = 1;
                  ys     = 1;
                  delay  = x_wait;
                  x_wait = x_interval;
                  y_wait = y_interval;
               end
            end else if (x_left != 0) begin
               xs    = 1;
               delay = x_interval;
            end else begin
               ys    = 1;
               delay = y_interval;
            end
            if (xs) begin
               x_held  = ring_pattern(x_phase);
               x_phase = x_phase + (x_fwd ? 3'd1 : 3'd7);
               x_left--;
            end
            if (ys) begin
               y_held  = ring_pattern(y_phase);
               y_phase = y_phase + (y_fwd ? 3'd1 : 3'd7);
               y_left--;
            end
            ev.accepted  = 1;
            ev.x_stepped = xs;
            ev.y_stepped = ys;
            ev.x_forward = x_fwd;
            ev.y_forward = y_fwd;
            ev.x_coils   = x_held;
            ev.y_coils   = y_held;
            ev.delay_us  = delay[tasl_pkg::DELAY_W-1:0];
            if (x_left == 0) x_held = 0;
            if (y_left == 0) y_held = 0;
            if (x_left == 0 && y_left == 0) begin
               moving       = 0;
               ev.move_done = 1;
            end
         end
         expected_q.push_back(ev);
         return ev.accepted;
      endfunction

      function void compare_field(string name, longint e, longint a);
         if (e != a) begin
            if (errors < REPORT_CAP)
               $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(step_event_type act);
         step_event_type exp;
         if (expected_q.size() == 0) begin
            if (errors < REPORT_CAP)
               $display("%0t: result with no item waiting, expected none actual %h",
                        $time, act);
            errors++;
         end else begin
            exp = expected_q.pop_front();
            compare_field("accepted",  longint'(exp.accepted),  longint'(act.accepted));
            compare_field("x_stepped", longint'(exp.x_stepped), longint'(act.x_stepped));
            compare_field("y_stepped", longint'(exp.y_stepped), longint'(act.y_stepped));
            compare_field("x_forward", longint'(exp.x_forward), longint'(act.x_forward));
            compare_field("y_forward", longint'(exp.y_forward), longint'(act.y_forward));
            compare_field("x_coils",   longint'(exp.x_coils),   longint'(act.x_coils));
            compare_field("y_coils",   longint'(exp.y_coils),   longint'(act.y_coils));
            compare_field("delay_us",  longint'(exp.delay_us),  longint'(act.delay_us));
            compare_field("move_done", longint'(exp.move_done), longint'(act.move_done));
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_mode = 1'b0;
   logic signed [tasl_pkg::DELTA_W-1:0] req_delta_x = '0;
   logic signed [tasl_pkg::DELTA_W-1:0] req_delta_y = '0;
   logic [tasl_pkg::SPEED_W-1:0]        req_speed = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_accepted;
   logic                                rsp_x_stepped;
   logic                                rsp_y_stepped;
   logic                                rsp_x_forward;
   logic                                rsp_y_forward;
   logic [tasl_pkg::COIL_W-1:0]         rsp_x_coils;
   logic [tasl_pkg::COIL_W-1:0]         rsp_y_coils;
   logic [tasl_pkg::DELAY_W-1:0]        rsp_delay_us;
   logic                                rsp_move_done;

   step_event_scoreboard sb = new();

   // calm turns off idling on both sides, hold_cycles asks the receiver for a long stall
   bit calm = 0;
   int hold_cycles = 0;

   // run statistics
   int n_items = 0;
   int n_moves = 0;
   int n_steps = 0;
   int n_ignored = 0;

   two_axis_stepper_line_mover dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_delta_x   (req_delta_x),
      .req_delta_y   (req_delta_y),
      .req_speed     (req_speed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_accepted  (rsp_accepted),
      .rsp_x_stepped (rsp_x_stepped),
      .rsp_y_stepped (rsp_y_stepped),
      .rsp_x_forward (rsp_x_forward),
      .rsp_y_forward (rsp_y_forward),
      .rsp_x_coils   (rsp_x_coils),
      .rsp_y_coils   (rsp_y_coils),
      .rsp_delay_us  (rsp_delay_us),
      .rsp_move_done (rsp_move_done)
   );

   always #10 clock = ~clock;

   // mostly short gaps, now and then a long one, none while calm
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // any 13-bit pattern, used where the block ignores the counts
   function automatic logic signed [tasl_pkg::DELTA_W-1:0] full_delta();
      logic signed [tasl_pkg::DELTA_W-1:0] d;
      d = tasl_pkg::DELTA_W'($urandom);
      return d;
   endfunction

   // any speed pattern, used where the block ignores the speed
   function automatic logic [tasl_pkg::SPEED_W-1:0] full_speed();
      return tasl_pkg::SPEED_W'($urandom);
   endfunction

   // mostly short moves so most of the run is spent on the stepping logic
   function automatic logic signed [tasl_pkg::DELTA_W-1:0] short_delta();
      int r, mag;
      r = $urandom_range(0, 99);
      if (r < 15)      mag = 0;
      else if (r < 80) mag = $urandom_range(1, 12);
      else if (r < 96) mag = $urandom_range(13, 60);
      else             mag = $urandom_range(61, 300);
      return tasl_pkg::DELTA_W'($urandom_range(0, 1) ? -mag : mag);
   endfunction

   function automatic logic [tasl_pkg::SPEED_W-1:0] pick_speed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return tasl_pkg::SPEED_MAX;
      if (r < 60) return tasl_pkg::SPEED_W'($urandom_range(1, 50));
      return tasl_pkg::SPEED_W'($urandom_range(0, 65535));
   endfunction

   // offer one item, hold it until accepted, then let the predictor see it
   task automatic offer_item(bit mode, logic signed [tasl_pkg::DELTA_W-1:0] dx,
                             logic signed [tasl_pkg::DELTA_W-1:0] dy,
                             logic [tasl_pkg::SPEED_W-1:0] spd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_delta_x <= dx;
      req_delta_y <= dy;
      req_speed   <= spd;
      do @(posedge clock); while (!req_ready);
      if (sb.note_item(mode, dx, dy, spd)) begin
         n_items++;
         if (mode == MODE_START) n_moves++;
         else n_steps++;
      end else begin
         n_ignored++;
      end
   endtask

   // advance until the predictor says the move is over, junk on the unused fields
   task automatic finish_move();
      while (sb.moving)
         offer_item(MODE_ADVANCE, full_delta(), full_delta(), full_speed());
   endtask

   // sender pause until every expected item has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // one random item: new moves when idle, step events while moving, a bit of noise
   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (!sb.moving) begin
         if (r < 6) offer_item(MODE_ADVANCE, full_delta(), full_delta(), full_speed());
         else offer_item(MODE_START, short_delta(), short_delta(), pick_speed());
      end else begin
         if (r < 8) offer_item(MODE_START, full_delta(), full_delta(), full_speed());
         else offer_item(MODE_ADVANCE, full_delta(), full_delta(), full_speed());
      end
   endtask

   // result side: random stalls, long hold-off on request, check every accepted item
   initial begin : result_sink
      int             stall;
      step_event_type act;
      wait (!reset);
      forever begin
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         act.accepted  = rsp_accepted;
         act.x_stepped = rsp_x_stepped;
         act.y_stepped = rsp_y_stepped;
         act.x_forward = rsp_x_forward;
         act.y_forward = rsp_y_forward;
         act.x_coils   = rsp_x_coils;
         act.y_coils   = rsp_y_coils;
         act.delay_us  = rsp_delay_us;
         act.move_done = rsp_move_done;
         sb.check_result(act);
      end
   end

   initial begin : stimulus
      int phase_end;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: rejected advance while idle, empty move, another idle advance
      offer_item(MODE_ADVANCE, '0, '0, '0);
      offer_item(MODE_START, 13'sd0, 13'sd0, 16'd123);
      offer_item(MODE_ADVANCE, DELTA_MAX, DELTA_MIN, tasl_pkg::SPEED_MAX);
      // x only, with a start while moving that must be rejected
      offer_item(MODE_START, 13'sd3, 13'sd0, 16'd10);
      offer_item(MODE_START, -13'sd5, 13'sd5, 16'd99);
      finish_move();
      // y only, backward, full speed
      offer_item(MODE_START, 13'sd0, -13'sd2, tasl_pkg::SPEED_MAX);
      finish_move();
      // zero speed, both axes tied the whole way
      offer_item(MODE_START, 13'sd2, 13'sd2, 16'd0);
      finish_move();
      // zero speed with one axis left over
      offer_item(MODE_START, 13'sd3, 13'sd1, 16'd0);
      finish_move();
      // uneven axes, partial wait dropped when one axis ends
      offer_item(MODE_START, -13'sd3, 13'sd5, 16'd7);
      finish_move();

      // long moves at full speed, delays far above 16 bits
      calm = 1;
      offer_item(MODE_START, 13'sd300, -13'sd1, tasl_pkg::SPEED_MAX);
      finish_move();
      offer_item(MODE_START, -13'sd250, 13'sd250, tasl_pkg::SPEED_MAX);
      finish_move();
      calm = 0;
      drain_results();

      // random phases, one calm, one with a long receiver hold-off
      n_items = 0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         calm      = (phase == 2);
         phase_end = n_items + PHASE_ITEMS;
         if (phase == 3) begin
            // long move, then the receiver stalls while advances keep coming
            offer_item(MODE_START, 13'sd180, -13'sd120, 16'd3);
            hold_cycles = HOLD_CYCLES;
            calm        = 1;
            repeat (100) offer_item(MODE_ADVANCE, full_delta(), full_delta(), full_speed());
            calm = 0;
         end
         while (n_items < phase_end) random_item();
         drain_results();
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, sb.pending());
         sb.errors++;
      end

      $display("covered %0d moves and %0d step events, %0d ignored items",
               n_moves, n_steps, n_ignored);
      $display("empty and long moves, zero and full speed, a %0d cycle receiver stall",
               HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
